### hw/rtl/ppm_pkg.sv
// Shared types and constants for the PPM stream decoder.
`default_nettype none
package ppm_pkg;

  localparam int DIM_BITS = 16;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       end_of_file;
  } ppm_in_t;

  typedef struct packed {
    logic [15:0] sample;
    logic        sample_valid;
    logic [1:0]  channel;
    logic        final_res;
    logic [2:0]  status;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [15:0] max_value;
  } ppm_out_t;

  // Work handed from the parser to the scaling back end.
  typedef struct packed {
    logic [15:0] raw;
    logic        sample_valid;
    logic [1:0]  channel;
    logic        final_res;
    logic [2:0]  status;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [15:0] max_value;
  } ppm_job_t;

  localparam logic [2:0] PH_MAGIC  = 3'd0;
  localparam logic [2:0] PH_WIDTH  = 3'd1;
  localparam logic [2:0] PH_HEIGHT = 3'd2;
  localparam logic [2:0] PH_MAXVAL = 3'd3;
  localparam logic [2:0] PH_P3     = 3'd4;
  localparam logic [2:0] PH_P6     = 3'd5;
  localparam logic [2:0] PH_DONE   = 3'd6;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_MAGIC    = 3'd1;
  localparam logic [2:0] ST_NUMBER   = 3'd2;
  localparam logic [2:0] ST_ZEROSIZE = 3'd3;
  localparam logic [2:0] ST_ZEROMAX  = 3'd4;
  localparam logic [2:0] ST_COUNT    = 3'd5;

  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [16:0] NUM_SAT = 17'h10000;
  localparam logic [33:0] SEEN_MAX = {34{1'b1}};
  localparam logic [16:0] DIM_LIM = 17'((18'd1 << DIM_BITS) - 18'd1);

  localparam int QDEPTH = 2;

endpackage
`default_nettype wire

### hw/rtl/ppm_front.sv
// Byte parser: header tokens, body samples and end-of-file checks.
`default_nettype none
module ppm_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  output logic                  in_full,
  input  wire ppm_pkg::ppm_in_t in_data,
  output logic                  job_push,
  input  wire logic             job_full,
  output ppm_pkg::ppm_job_t     job_data
);
  import ppm_pkg::*;

  logic [2:0]  phase_r;
  logic        cmt_r, tok_r, bin_r;
  logic [16:0] mc_r, acc_r;
  logic [15:0] w_r, h_r, mv_r;
  logic [8:0]  hb_r;
  logic [1:0]  ch_r;
  logic [33:0] seen_r;
  logic [2:0]  err_r;

  logic [2:0]  phase_n;
  logic        cmt_n, tok_n, bin_n;
  logic [16:0] mc_n, acc_n;
  logic [15:0] w_n, h_n, mv_n;
  logic [8:0]  hb_n;
  logic [1:0]  ch_n;
  logic [33:0] seen_n;
  logic [2:0]  err_n;
  logic        emit;
  logic [15:0] ev;
  logic [1:0]  ech;

  logic [7:0] c;
  logic       eof, take;
  assign c = in_data.file_byte;
  assign eof = in_data.end_of_file;
  assign in_full = job_full;
  assign take = in_push && !job_full;

  function automatic logic is_ws(input logic [7:0] x);
    return x == 8'h20 || (x >= 8'd9 && x <= 8'd13);
  endfunction
  function automatic logic is_dig(input logic [7:0] x);
    return x >= 8'h30 && x <= 8'h39;
  endfunction
  function automatic logic [16:0] accum(input logic [16:0] a, input logic [7:0] x);
    logic [21:0] v;
    v = {2'b0, a, 3'b0} + {4'b0, a, 1'b0} + {14'b0, x - 8'h30};
    return (v > {5'b0, NUM_SAT}) ? NUM_SAT : v[16:0];
  endfunction

  logic [31:0] wh;
  logic [33:0] need;
  assign wh = 32'(w_r) * 32'(h_r);
  assign need = {2'b0, wh} + {1'b0, wh, 1'b0};

  always_comb begin
    logic [16:0] lim;
    logic        fin;
    phase_n = phase_r; cmt_n = cmt_r; tok_n = tok_r; bin_n = bin_r;
    mc_n = mc_r; acc_n = acc_r; w_n = w_r; h_n = h_r; mv_n = mv_r;
    hb_n = hb_r; ch_n = ch_r; seen_n = seen_r; err_n = err_r;
    emit = 1'b0; ev = '0; ech = '0; fin = 1'b0; lim = '0;
    if (phase_r <= PH_MAXVAL) begin
      if (cmt_r) begin
        if (c == CH_LF) cmt_n = 1'b0;
      end else if (c == CH_HASH) begin
        cmt_n = 1'b1;
      end else if (is_ws(c)) begin
        fin = tok_r;
      end else begin
        if (phase_r == PH_MAGIC) begin
          if (acc_r == 17'd0) mc_n = mc_r | {1'b0, c, 8'h00};
          else if (acc_r == 17'd1) mc_n = mc_r | {9'b0, c};
          else mc_n = mc_r | 17'h10000;
          if (acc_r < 17'd3) acc_n = acc_r + 17'd1;
        end else if (!mc_r[1]) begin
          if (is_dig(c)) begin
            acc_n = accum(acc_r, c); mc_n = mc_r | 17'd1;
          end else mc_n = mc_r | 17'd2;
        end
        tok_n = 1'b1;
      end
      if (take && eof && !fin && tok_n) fin = 1'b1;
    end else if (phase_r == PH_P3) begin
      if (cmt_r) begin
        if (c == CH_LF) begin cmt_n = 1'b0; mc_n = 17'd1; end
      end else if (tok_r && is_dig(c)) begin
        acc_n = accum(acc_r, c);
      end else begin
        if (tok_r) begin
          emit = 1'b1;
          ev = acc_r[16] ? 16'hFFFF : acc_r[15:0];
          tok_n = 1'b0; acc_n = '0;
        end
        if (is_ws(c)) begin
        end else if (is_dig(c)) begin
          acc_n = accum(17'd0, c); tok_n = 1'b1; mc_n = '0;
        end else if (c == CH_HASH && !mc_r[0]) begin
          cmt_n = 1'b1;
        end else phase_n = PH_DONE;
      end
      if (eof && tok_n && !emit) begin
        emit = 1'b1;
        ev = acc_n[16] ? 16'hFFFF : acc_n[15:0];
        tok_n = 1'b0;
      end
    end else if (phase_r == PH_P6) begin
      if (mv_r <= 16'd255) begin
        emit = 1'b1; ev = {8'h00, c};
      end else if (hb_r[8]) begin
        emit = 1'b1; ev = {hb_r[7:0], c}; hb_n = '0;
      end else hb_n = {1'b1, c};
    end
    if (fin) begin
      if (phase_r == PH_MAGIC) begin
        if (acc_n == 17'd2 && mc_n == 17'h05033) begin
          bin_n = 1'b0; phase_n = PH_WIDTH;
        end else if (acc_n == 17'd2 && mc_n == 17'h05036) begin
          bin_n = 1'b1; phase_n = PH_WIDTH;
        end else begin
          err_n = ST_MAGIC; phase_n = PH_DONE;
        end
      end else begin
        lim = (phase_r == PH_MAXVAL) ? 17'd65535 : DIM_LIM;
        if (!mc_n[0] || acc_n > lim) begin
          err_n = ST_NUMBER; phase_n = PH_DONE;
        end else if (phase_r == PH_WIDTH) begin
          w_n = acc_n[15:0]; phase_n = PH_HEIGHT;
        end else if (phase_r == PH_HEIGHT) begin
          h_n = acc_n[15:0]; phase_n = PH_MAXVAL;
        end else begin
          mv_n = acc_n[15:0];
          if (w_r == 16'd0 || h_r == 16'd0) begin
            err_n = ST_ZEROSIZE; phase_n = PH_DONE;
          end else if (acc_n[15:0] == 16'd0) begin
            err_n = ST_ZEROMAX; phase_n = PH_DONE;
          end else phase_n = bin_n ? PH_P6 : PH_P3;
        end
      end
      tok_n = 1'b0; mc_n = '0; acc_n = '0;
    end
    if (eof && phase_n <= PH_MAXVAL) begin
      err_n = ST_NUMBER; phase_n = PH_DONE;
    end
    if (emit) begin
      ech = ch_r;
      ch_n = (ch_r >= 2'd2) ? 2'd0 : ch_r + 2'd1;
      if (seen_r != SEEN_MAX) seen_n = seen_r + 34'd1;
    end
    if (eof && phase_n == PH_P6 && seen_n != need) err_n = ST_COUNT;
  end

  assign job_push = take && (emit || eof);
  always_comb begin
    job_data.raw = ev;
    job_data.sample_valid = emit;
    job_data.channel = ech;
    job_data.final_res = eof;
    job_data.status = err_n;
    job_data.image_width = w_n;
    job_data.image_height = h_n;
    job_data.max_value = mv_n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && eof)) begin
      phase_r <= PH_MAGIC; cmt_r <= 1'b0; tok_r <= 1'b0; bin_r <= 1'b0;
      mc_r <= '0; acc_r <= '0; w_r <= '0; h_r <= '0; mv_r <= '0;
      hb_r <= '0; ch_r <= '0; seen_r <= '0; err_r <= ST_OK;
    end else if (take) begin
      phase_r <= phase_n; cmt_r <= cmt_n; tok_r <= tok_n; bin_r <= bin_n;
      mc_r <= mc_n; acc_r <= acc_n; w_r <= w_n; h_r <= h_n; mv_r <= mv_n;
      hb_r <= hb_n; ch_r <= ch_n; seen_r <= seen_n; err_r <= err_n;
    end
  end
endmodule
`default_nettype wire

### hw/rtl/ppm_queue.sv
// Two-entry queue between parser and scaler.
`default_nettype none
module ppm_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  output logic                   full,
  input  wire ppm_pkg::ppm_job_t wdata,
  input  wire logic              pop,
  output logic                   empty,
  output ppm_pkg::ppm_job_t      rdata
);
  import ppm_pkg::*;

  ppm_job_t mem_r [QDEPTH];
  logic [$clog2(QDEPTH)-1:0] wp_r, rp_r;
  logic [$clog2(QDEPTH):0]   cnt_r;

  assign full  = cnt_r == ($clog2(QDEPTH)+1)'(QDEPTH);
  assign empty = cnt_r == '0;
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push && !full) wp_r <= wp_r + 1'b1;
      if (pop && !empty) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + ($clog2(QDEPTH)+1)'(push && !full)
                     - ($clog2(QDEPTH)+1)'(pop && !empty);
    end
  end
endmodule
`default_nettype wire

### hw/rtl/ppm_scale.sv
// Scaler: sample*K/maxval with a radix-2 restoring divider, plus output register.
`default_nettype none
module ppm_scale (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              job_empty,
  output logic                   job_pop,
  input  wire ppm_pkg::ppm_job_t job_data,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output ppm_pkg::ppm_out_t      out_data
);
  import ppm_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0]  st_r;
  logic [5:0]  cnt_r;
  logic [31:0] q_r;
  logic [15:0] rem_r;
  ppm_job_t    job_r;
  logic        ov_r;
  ppm_out_t    out_r;

  // Remainder stays below the divisor, so one extra bit holds the borrow.
  logic [17:0] trial;
  assign trial = {1'b0, rem_r, q_r[31]} - {2'b0, job_r.max_value};

  logic load_out;
  assign load_out = (st_r == S_DIV) && (cnt_r == 6'd32) && (!ov_r || out_pop);

  assign job_pop = (st_r == S_IDLE) && !job_empty;
  assign out_empty = !ov_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (load_out) ov_r <= 1'b1;
      else if (out_pop && ov_r) ov_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (!job_empty) begin
          job_r <= job_data;
          st_r <= S_MUL;
        end
        S_MUL: begin
          q_r <= 32'(job_r.raw) * ((job_r.max_value <= 16'd255) ? 32'd255 : 32'd65535);
          rem_r <= '0; cnt_r <= '0;
          st_r <= S_DIV;
        end
        S_DIV: begin
          if (cnt_r != 6'd32) begin
            if (!trial[17]) begin
              rem_r <= trial[15:0]; q_r <= {q_r[30:0], 1'b1};
            end else begin
              rem_r <= {rem_r[14:0], q_r[31]}; q_r <= {q_r[30:0], 1'b0};
            end
            cnt_r <= cnt_r + 6'd1;
          end else if (load_out) begin
            out_r.sample <= (job_r.sample_valid && job_r.max_value != 16'd0)
                            ? q_r[15:0] : 16'd0;
            out_r.sample_valid <= job_r.sample_valid;
            out_r.channel <= job_r.channel;
            out_r.final_res <= job_r.final_res;
            out_r.status <= job_r.status;
            out_r.image_width <= job_r.image_width;
            out_r.image_height <= job_r.image_height;
            out_r.max_value <= job_r.max_value;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### hw/rtl/ppm_stream_decoder.sv
// Top level of the PPM stream decoder.
`default_nettype none
// Decodes a P3 or P6 PPM file fed one byte per beat and returns a result for
// each color sample and one for the end-of-file byte, with status and header.
// The parser takes a byte per cycle into a two-entry queue while the queue has
// room; the scaler handles one result at a time (job load, one multiply step,
// 32 radix-2 divide steps and the output register load, which waits while an
// unread result still holds the output register) and takes no new job until
// it is done, while bytes that make no result pass one per cycle.
module ppm_stream_decoder (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  output logic                  in_full,
  input  wire ppm_pkg::ppm_in_t in_data,
  output logic                  out_empty,
  input  wire logic             out_pop,
  output ppm_pkg::ppm_out_t     out_data
);
  import ppm_pkg::*;

  logic     jpush, jfull, jpop, jempty;
  ppm_job_t jw, jr;

  ppm_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data,
    .job_push(jpush), .job_full(jfull), .job_data(jw)
  );
  ppm_queue u_queue (
    .clk, .rst_n, .push(jpush), .full(jfull), .wdata(jw),
    .pop(jpop), .empty(jempty), .rdata(jr)
  );
  ppm_scale u_scale (
    .clk, .rst_n, .job_empty(jempty), .job_pop(jpop), .job_data(jr),
    .out_empty, .out_pop, .out_data
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    jfull |-> !(jpush && !jfull)) else $error("queue overrun");
  a_chan: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_data.channel != 2'd3) else $error("bad channel");
  a_noval: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.sample_valid) |-> out_data.final_res)
    else $error("empty result");
endmodule
`default_nettype wire

### bench/ppm_stream_checker.sv
// Checker for the PPM stream decoder: predicts results from accepted bytes and compares.
`default_nettype none
module ppm_stream_checker (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  input  wire logic             in_full,
  input  wire ppm_pkg::ppm_in_t in_data,
  input  wire logic             out_empty,
  input  wire logic             out_pop,
  input  wire ppm_pkg::ppm_out_t out_data,
  output int                    fail_count,
  output int                    pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import ppm_pkg::*;

  ppm_out_t expected_results[$];

  logic [2:0]  phase;
  logic        comment_on, tok_on, bin_fmt;
  logic [16:0] chars, acc;
  logic [15:0] wid, hgt, maxv;
  logic [8:0]  hi_hold;
  logic [1:0]  chan;
  logic [33:0] seen;
  logic [2:0]  err;
  logic        emitted;
  logic [15:0] emit_val;
  logic [1:0]  emit_chan;

  function automatic bit is_space(logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  task automatic clear_decoder();
    phase = PH_MAGIC; comment_on = 0; tok_on = 0; chars = 0; acc = 0;
    bin_fmt = 0; wid = 0; hgt = 0; maxv = 0; hi_hold = 0; chan = 0;
    seen = 0; err = ST_OK;
  endtask

  task automatic add_digit(logic [7:0] c);
    logic [31:0] v;
    v = 32'(acc) * 10 + 32'(c - 8'h30);
    acc = v > 32'(NUM_SAT) ? NUM_SAT : v[16:0];
  endtask

  task automatic abort_with(logic [2:0] code);
    err = code; phase = PH_DONE; tok_on = 0; chars = 0; acc = 0;
  endtask

  task automatic push_sample(logic [16:0] v);
    logic [31:0] k, q;
    k = maxv <= 16'd255 ? 32'd255 : 32'd65535;
    q = maxv == 0 ? 32'd0 : (32'(v) * k) / 32'(maxv);
    emitted = 1; emit_val = q[15:0]; emit_chan = chan;
    chan = chan >= 2 ? 2'd0 : chan + 2'd1;
    if (seen != SEEN_MAX) seen++;
  endtask

  task automatic close_token();
    logic [16:0] lim;
    if (phase == PH_MAGIC) begin
      if (acc == 2 && chars == 17'h5033) bin_fmt = 0;
      else if (acc == 2 && chars == 17'h5036) bin_fmt = 1;
      else begin abort_with(ST_MAGIC); return; end
      phase = PH_WIDTH; tok_on = 0; chars = 0; acc = 0;
      return;
    end
    lim = phase == PH_MAXVAL ? 17'd65535 : DIM_LIM;
    if (!chars[0] || acc > lim) begin abort_with(ST_NUMBER); return; end
    if (phase == PH_WIDTH) wid = acc[15:0];
    else if (phase == PH_HEIGHT) hgt = acc[15:0];
    else maxv = acc[15:0];
    tok_on = 0; chars = 0; acc = 0;
    if (phase != PH_MAXVAL) begin phase++; return; end
    if (wid == 0 || hgt == 0) begin abort_with(ST_ZEROSIZE); return; end
    if (maxv == 0) begin abort_with(ST_ZEROMAX); return; end
    phase = bin_fmt ? PH_P6 : PH_P3;
  endtask

  task automatic header_step(logic [7:0] c);
    if (comment_on) begin
      if (c == CH_LF) comment_on = 0;
      return;
    end
    if (c == CH_HASH) begin comment_on = 1; return; end
    if (is_space(c)) begin
      if (tok_on) close_token();
      return;
    end
    if (phase == PH_MAGIC) begin
      if (acc == 0) chars |= {1'b0, c, 8'h00};
      else if (acc == 1) chars |= {9'h0, c};
      else chars |= 17'h10000;
      if (acc < 3) acc++;
    end else if (!chars[1]) begin
      if (is_digit(c)) begin add_digit(c); chars |= 17'd1; end
      else chars |= 17'd2;
    end
    tok_on = 1;
  endtask

  task automatic ascii_body_step(logic [7:0] c);
    if (comment_on) begin
      if (c == CH_LF) begin comment_on = 0; chars = 1; end
      return;
    end
    if (tok_on) begin
      if (is_digit(c)) begin add_digit(c); return; end
      push_sample(acc > 17'd65535 ? 17'd65535 : acc);
      tok_on = 0; acc = 0;
    end
    if (is_space(c)) return;
    if (is_digit(c)) begin
      acc = 0; add_digit(c); tok_on = 1; chars = 0;
      return;
    end
    if (c == CH_HASH && !chars[0]) begin comment_on = 1; return; end
    phase = PH_DONE;
  endtask

  task automatic binary_body_step(logic [7:0] c);
    if (maxv <= 16'd255) begin push_sample({9'h0, c}); return; end
    if (hi_hold[8]) begin
      push_sample({1'b0, hi_hold[7:0], c});
      hi_hold = 0;
    end else begin
      hi_hold = {1'b1, c};
    end
  endtask

  task automatic predict_byte(ppm_in_t b);
    ppm_out_t r;
    emitted = 0; emit_val = 0; emit_chan = 0;
    if (phase <= PH_MAXVAL) header_step(b.file_byte);
    else if (phase == PH_P3) ascii_body_step(b.file_byte);
    else if (phase == PH_P6) binary_body_step(b.file_byte);
    if (b.end_of_file) begin
      if (phase <= PH_MAXVAL) begin
        if (tok_on) close_token();
        if (phase <= PH_MAXVAL) abort_with(ST_NUMBER);
      end
      if (phase == PH_P3 && tok_on) begin
        push_sample(acc > 17'd65535 ? 17'd65535 : acc);
        tok_on = 0;
      end
      if (phase == PH_P6 && 34'(wid) * 34'(hgt) * 34'd3 != seen) err = ST_COUNT;
    end
    if (!emitted && !b.end_of_file) return;
    r.sample = emit_val; r.sample_valid = emitted; r.channel = emit_chan;
    r.final_res = b.end_of_file; r.status = err;
    r.image_width = wid; r.image_height = hgt; r.max_value = maxv;
    expected_results.insert(expected_results.size(), r);
    if (b.end_of_file) clear_decoder();
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
    clear_decoder();
  end

  always @(posedge clk) begin
    ppm_out_t w;
    if (!rst_n) begin
      clear_decoder();
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          w = expected_results.pop_front();
          if (out_data.sample != w.sample)
            report_mismatch("sample", int'(out_data.sample), int'(w.sample));
          if (out_data.sample_valid != w.sample_valid)
            report_mismatch("sample_valid", int'(out_data.sample_valid),
                            int'(w.sample_valid));
          if (out_data.channel != w.channel)
            report_mismatch("channel", int'(out_data.channel), int'(w.channel));
          if (out_data.final_res != w.final_res)
            report_mismatch("final_res", int'(out_data.final_res), int'(w.final_res));
          if (out_data.status != w.status)
            report_mismatch("status", int'(out_data.status), int'(w.status));
          if (out_data.image_width != w.image_width)
            report_mismatch("image_width", int'(out_data.image_width),
                            int'(w.image_width));
          if (out_data.image_height != w.image_height)
            report_mismatch("image_height", int'(out_data.image_height),
                            int'(w.image_height));
          if (out_data.max_value != w.max_value)
            report_mismatch("max_value", int'(out_data.max_value), int'(w.max_value));
        end
      end
      if (in_push && !in_full) predict_byte(in_data);
    end
    pending_count = expected_results.size();
  end
endmodule
`default_nettype wire

### bench/ppm_stream_decoder_tb.sv
// Top of the PPM stream decoder testbench: clock, reset, byte stimulus and verdict.
`default_nettype none
module ppm_stream_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ppm_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic     clk = 0;
  logic     rst_n = 0;
  logic     in_push = 0;
  ppm_in_t  in_data = '0;
  logic     out_pop = 0;
  logic     in_full, out_empty;
  ppm_out_t out_data;
  int       fail_count, pending_count;
  int       cycles = 0;
  int       bytes_sent = 0;
  byte unsigned file_bytes[$];

  ppm_stream_decoder dut (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );

  ppm_stream_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver stalls in runs; some stretches never stall.
  int stall_run = 0;
  int stall_mode = 0;
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_run <= $urandom_range(5, 60);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      0: out_pop <= 1'b1;
      1: out_pop <= ($urandom_range(0, 3) != 0);
      2: out_pop <= ($urandom_range(0, 3) == 0);
      default: out_pop <= stall_run[2];
    endcase
  end

  task automatic put_byte(input logic [7:0] b);
    file_bytes.insert(file_bytes.size(), b);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  function automatic string pick_space();
    case ($urandom_range(0, 6))
      0: return "\t";
      1: return "\n";
      2: return "\r";
      3: return "\v";
      4: return "\f";
      5: return "  ";
      default: return " ";
    endcase
  endfunction

  // Send a file; the last byte carries end_of_file. Sender bursts with gaps.
  task automatic send_file();
    int gap;
    int burst;
    burst = $urandom_range(1, 20);
    while (file_bytes.size() > 0) begin
      in_data.file_byte <= file_bytes.pop_front();
      in_data.end_of_file <= (file_bytes.size() == 0);
      in_push <= 1'b1;
      do @(posedge clk); while (in_full);
      @(negedge clk);
      bytes_sent++;
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          in_push <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
    in_push <= 1'b0;
    // idle so the next file starts on a later edge
    @(negedge clk);
  endtask

  task automatic random_file();
    int kind, w, h, mv, n, mode;
    bit bin;
    kind = $urandom_range(0, 9);
    bin = $urandom_range(0, 1);
    w = $urandom_range(1, 3);
    h = $urandom_range(1, 2);
    mode = $urandom_range(0, 3);
    mv = mode == 0 ? 255 : mode == 1 ? $urandom_range(1, 255) :
         mode == 2 ? $urandom_range(256, 65535) : 65535;
    if (kind == 0) begin
      // noise bytes
      n = $urandom_range(1, 12);
      repeat (n) put_byte(8'($urandom_range(0, 255)));
      return;
    end
    add_text(bin ? "P6" : "P3");
    if (kind == 1) add_text("#x P3\n");
    add_text(pick_space());
    add_text($sformatf("%0d", w));
    add_text(pick_space());
    if ($urandom_range(0, 3) == 0) add_text("# note\n");
    add_text($sformatf("%0d", h));
    add_text(pick_space());
    if (kind == 2) begin
      return;
    end
    add_text($sformatf("%0d", mv));
    put_byte($urandom_range(0, 1) ? 8'h0a : 8'h20);
    n = w * h * 3;
    if (kind == 3) n = n + $urandom_range(0, 2) - 1;
    for (int i = 0; i < n; i++) begin
      if (bin) begin
        if (mv > 255) put_byte(8'($urandom_range(0, 255)));
        put_byte(8'($urandom_range(0, 255)));
      end else begin
        add_text($sformatf("%0d", kind == 4 ? $urandom_range(0, 99999) : $urandom_range(0, mv)));
        add_text(pick_space());
        if (kind == 5 && i == 1) add_text("# c\n");
      end
    end
    if (bin && kind == 6 && mv > 255) put_byte(8'($urandom_range(0, 255)));
    if (!bin && kind == 7) add_text("x 12 ");
    if (file_bytes.size() == 0) put_byte(8'h20);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed files
    add_text("P3 1 1 255 0 128 255"); send_file();
    add_text("P6\n1 1\n65535\n"); put_byte(8'hff); put_byte(8'hff);
    put_byte(8'h00); put_byte(8'h00);
    put_byte(8'h80); put_byte(8'h01); send_file();
    add_text("P6 1 1 1 "); put_byte(8'h01); put_byte(8'h00);
    put_byte(8'hff); send_file();
    add_text("P5 1 1 255 "); send_file();
    add_text("P33 1 1 255 "); send_file();
    add_text("P3 -1 1 255 "); send_file();
    add_text("P3 65536 1 255 "); send_file();
    add_text("P3 1 1 65536 "); send_file();
    add_text("P3 0 1 255 1 "); send_file();
    add_text("P3 1 1 0 1 "); send_file();
    add_text("P3 2 1"); send_file();
    add_text("P3 1 1 300 99999 0 1# c\n# 5"); send_file();
    add_text("P3 1 1 255 1 2 x 3"); send_file();
    add_text("P6 1 1 300 "); put_byte(8'h12); send_file();
    add_text("P6 1 1 255 "); put_byte(8'h00); send_file();
    add_text("P3 1 1 255 12a 3 4"); send_file();
    while (bytes_sent < 1250) begin
      random_file();
      send_file();
    end
    while (pending_count > 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
